FILE: rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at each rising clock edge, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication checked at each rising clock edge, off while reset is high
`define ASSERT_IMPLY(label, clk, rst, cond, conseq, msg) \
   `ASSERT_CLK(label, clk, rst, (cond) |-> (conseq), msg)

`endif

FILE: rtl/i2cra_pkg.sv
// types and constants of the i2c register access master
package i2cra_pkg;

   localparam int unsigned SLAVE_ADDRESS_W = 7;
   localparam int unsigned ACK_TIMEOUT_W   = 8;
   localparam int unsigned BYTE_W          = 8;
   localparam int unsigned MODE_W          = 2;
   localparam int unsigned CSR_DATA_W      = 8;
   localparam int unsigned CSR_INDEX_W     = 1;
   localparam int unsigned REQ_DATA_W      = 24;
   localparam int unsigned RSP_DATA_W      = 16;

   localparam logic [SLAVE_ADDRESS_W-1:0] SLAVE_ADDRESS_RESET = 7'd104;
   localparam logic [ACK_TIMEOUT_W-1:0]   ACK_TIMEOUT_RESET   = 8'd250;

   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SLAVE_ADDRESS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_TIMEOUT   = 1'd1;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_WRITE,
      CMD_READ
   } cmd_kind_type;

   // one classified request waiting for the bus engine
   typedef struct packed {
      cmd_kind_type          kind;
      logic                  sda_in;
      logic [BYTE_W-1:0]     reg_address;
      logic [BYTE_W-1:0]     write_value;
   } cmd_type;

   // result fields, declared high to low so scl_level lands in bit 0
   typedef struct packed {
      logic              rejected;
      logic [BYTE_W-1:0] read_byte;
      logic              nack_error;
      logic              done_res;
      logic              busy_res;
      logic              sda_drive;
      logic              sda_level;
      logic              scl_level;
   } result_type;

endpackage

FILE: rtl/i2c_register_access_master.sv
// I2C register access master: every request is one bus phase tick and yields exactly one
// response with the line levels for that tick. A tick request in idle with mode 1 (write)
// or mode 2 (read) starts a single-register transaction against the slave address
// register; requests of those modes while busy are flagged rejected and act as plain
// ticks. One request per clock is sustained while the response port does not stall: a queue
// of QUEUE_DEPTH entries sits between the request port and the phase sequencer, and the
// sequencer advances one tick per clock into a response register, so a request passes
// through the queue and then the response register. Configuration writes belong in idle
// periods.
module i2c_register_access_master #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [0] sda_in, [8:1] reg_address, [16:9] write_value, rest zero
   input  logic [i2cra_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [1:0] mode
   input  logic [i2cra_pkg::MODE_W-1:0]          req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
   // [5] nack_error, [13:6] read_byte, [14] rejected, [15] zero
   output logic [i2cra_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                  csr_we,
   input  logic [i2cra_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [i2cra_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic                  cmd_valid;
   logic                  cmd_pop;
   i2cra_pkg::cmd_type    cmd;
   i2cra_pkg::result_type rsp_result;

   i2cra_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (req_tvalid),
      .push_ready  (req_tready),
      .mode        (req_tuser),
      .sda_in      (req_tdata[0]),
      .reg_address (req_tdata[8:1]),
      .write_value (req_tdata[16:9]),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   i2cra_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_result (rsp_result),
      .rsp_ready  (rsp_tready)
   );

   assign rsp_tdata = {1'b0, rsp_result};

endmodule

FILE: rtl/i2cra_front.sv
// request classifier and command queue in front of the bus engine
module i2cra_front #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   output logic                         push_ready,
   input  logic [i2cra_pkg::MODE_W-1:0] mode,
   input  logic                         sda_in,
   input  logic [i2cra_pkg::BYTE_W-1:0] reg_address,
   input  logic [i2cra_pkg::BYTE_W-1:0] write_value,
   output logic                         cmd_valid,
   output i2cra_pkg::cmd_type           cmd,
   input  logic                         cmd_pop
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   i2cra_pkg::cmd_type entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   i2cra_pkg::cmd_type new_cmd;
   logic               push, pop;

   always_comb begin
      new_cmd.sda_in      = sda_in;
      new_cmd.reg_address = reg_address;
      new_cmd.write_value = write_value;
      case (mode)
         i2cra_pkg::MODE_WRITE: new_cmd.kind = i2cra_pkg::CMD_WRITE;
         i2cra_pkg::MODE_READ:  new_cmd.kind = i2cra_pkg::CMD_READ;
         default:               new_cmd.kind = i2cra_pkg::CMD_TICK;
      endcase
   end

   assign push_ready = (count_ff != FULL_CNT);
   assign cmd_valid  = (count_ff != '0);
   assign cmd        = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

FILE: rtl/i2cra_engine.sv
// bus phase sequencer with configuration registers and result register
module i2cra_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [i2cra_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [i2cra_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                              cmd_valid,
   input  i2cra_pkg::cmd_type                cmd,
   output logic                              cmd_pop,
   output logic                              rsp_valid,
   output i2cra_pkg::result_type             rsp_result,
   input  logic                              rsp_ready
);

   typedef enum logic [4:0] {
      PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C,
      PH_TX_SET, PH_TX_HIGH, PH_TX_LOW,
      PH_ACK_REL, PH_ACK_WAIT,
      PH_RX_LOW, PH_RX_HIGH,
      PH_NK_SET, PH_NK_HIGH, PH_NK_LOW,
      PH_SP_A, PH_SP_B, PH_SP_C
   } phase_type;

   typedef enum logic [2:0] {
      STG_ADDR_W, STG_REG, STG_VALUE, STG_ADDR_R, STG_RECV
   } stage_type;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   phase_type  phase_ff, phase_in;
   stage_type  stage_ff, stage_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_byte_ff, shift_byte_in;
   logic [7:0] wait_count_ff, wait_count_in;
   logic [7:0] captured_byte_ff, captured_byte_in;
   logic       is_read_ff, is_read_in;
   logic       fault_ff, fault_in;
   logic [7:0] latched_address_ff, latched_address_in;
   logic [7:0] latched_value_ff, latched_value_in;
   logic [i2cra_pkg::SLAVE_ADDRESS_W-1:0] slave_address_ff, slave_address_in;
   logic [i2cra_pkg::ACK_TIMEOUT_W-1:0]   ack_timeout_ff, ack_timeout_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   i2cra_pkg::result_type rsp_result_ff, rsp_result_in;

   i2cra_pkg::result_type res;
   phase_type             cur_phase;
   logic                  is_request;
   logic                  pop;
   logic [3:0]            bit_next;
   logic [7:0]            rx_byte;
   logic [7:0]            addr_w;

   // the result register frees up in the same cycle it is taken
   assign pop       = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign cmd_pop   = pop;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   always_comb begin
      slave_address_in = slave_address_ff;
      ack_timeout_in   = ack_timeout_ff;
      if (csr_we) begin
         case (csr_index)
            i2cra_pkg::CSR_SLAVE_ADDRESS:
               slave_address_in = csr_wdata[i2cra_pkg::SLAVE_ADDRESS_W-1:0];
            i2cra_pkg::CSR_ACK_TIMEOUT:
               ack_timeout_in = csr_wdata[i2cra_pkg::ACK_TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in           = phase_ff;
      stage_in           = stage_ff;
      bit_count_in       = bit_count_ff;
      shift_byte_in      = shift_byte_ff;
      wait_count_in      = wait_count_ff;
      captured_byte_in   = captured_byte_ff;
      is_read_in         = is_read_ff;
      fault_in           = fault_ff;
      latched_address_in = latched_address_ff;
      latched_value_in   = latched_value_ff;
      res                = '0;
      res.scl_level      = 1'b1;
      res.sda_level      = 1'b1;
      res.sda_drive      = 1'b1;
      res.busy_res       = 1'b1;
      cur_phase          = phase_ff;
      is_request         = (cmd.kind != i2cra_pkg::CMD_TICK);
      bit_next           = bit_count_ff + 4'd1;
      rx_byte            = {shift_byte_ff[6:0], cmd.sda_in};
      addr_w             = {slave_address_ff, 1'b0};

      if (pop) begin
         // a request in idle already is the first start tick
         if (phase_ff == PH_IDLE) begin
            if (is_request) begin
               is_read_in         = (cmd.kind == i2cra_pkg::CMD_READ);
               latched_address_in = cmd.reg_address;
               latched_value_in   = cmd.write_value;
               captured_byte_in   = '0;
               fault_in           = 1'b0;
               stage_in           = STG_ADDR_W;
               cur_phase          = PH_ST_A;
            end
         end else if (is_request) begin
            res.rejected = 1'b1;
         end

         case (cur_phase)
            PH_ST_A: begin
               phase_in = PH_ST_B;
            end
            PH_ST_B: begin
               res.sda_level = 1'b0;
               phase_in      = PH_ST_C;
            end
            PH_ST_C: begin
               res.scl_level = 1'b0;
               res.sda_level = 1'b0;
               bit_count_in  = '0;
               phase_in      = PH_TX_SET;
               if (stage_ff == STG_ADDR_R) begin
                  shift_byte_in = addr_w | 8'h01;
                  stage_in      = STG_ADDR_R;
               end else begin
                  shift_byte_in = addr_w;
                  stage_in      = STG_ADDR_W;
               end
            end
            PH_TX_SET: begin
               res.scl_level = 1'b0;
               res.sda_level = shift_byte_ff[7];
               phase_in      = PH_TX_HIGH;
            end
            PH_TX_HIGH: begin
               res.sda_level = shift_byte_ff[7];
               phase_in      = PH_TX_LOW;
            end
            PH_TX_LOW: begin
               res.scl_level = 1'b0;
               res.sda_level = shift_byte_ff[7];
               shift_byte_in = {shift_byte_ff[6:0], 1'b0};
               bit_count_in  = bit_next;
               phase_in      = (bit_next >= BITS_PER_BYTE) ? PH_ACK_REL : PH_TX_SET;
            end
            PH_ACK_REL: begin
               res.scl_level = 1'b0;
               res.sda_level = 1'b0;
               res.sda_drive = 1'b0;
               wait_count_in = '0;
               phase_in      = PH_ACK_WAIT;
            end
            PH_ACK_WAIT: begin
               res.sda_level = 1'b0;
               res.sda_drive = 1'b0;
               if (!cmd.sda_in) begin
                  case (stage_ff)
                     STG_ADDR_W: begin
                        shift_byte_in = latched_address_ff;
                        bit_count_in  = '0;
                        stage_in      = STG_REG;
                        phase_in      = PH_TX_SET;
                     end
                     STG_REG: begin
                        if (is_read_ff) begin
                           phase_in = PH_SP_A;
                        end else begin
                           shift_byte_in = latched_value_ff;
                           bit_count_in  = '0;
                           stage_in      = STG_VALUE;
                           phase_in      = PH_TX_SET;
                        end
                     end
                     STG_ADDR_R: begin
                        stage_in      = STG_RECV;
                        bit_count_in  = '0;
                        shift_byte_in = '0;
                        phase_in      = PH_RX_LOW;
                     end
                     default: begin
                        phase_in = PH_SP_A;
                     end
                  endcase
               end else if (wait_count_ff >= ack_timeout_ff) begin
                  fault_in = 1'b1;
                  phase_in = PH_SP_A;
               end else begin
                  wait_count_in = wait_count_ff + 8'd1;
               end
            end
            PH_RX_LOW: begin
               res.scl_level = 1'b0;
               res.sda_level = 1'b0;
               res.sda_drive = 1'b0;
               phase_in      = PH_RX_HIGH;
            end
            PH_RX_HIGH: begin
               res.sda_level = 1'b0;
               res.sda_drive = 1'b0;
               shift_byte_in = rx_byte;
               bit_count_in  = bit_next;
               if (bit_next >= BITS_PER_BYTE) begin
                  captured_byte_in = rx_byte;
                  phase_in         = PH_NK_SET;
               end else begin
                  phase_in = PH_RX_LOW;
               end
            end
            PH_NK_SET: begin
               res.scl_level = 1'b0;
               phase_in      = PH_NK_HIGH;
            end
            PH_NK_HIGH: begin
               phase_in = PH_NK_LOW;
            end
            PH_NK_LOW: begin
               res.scl_level = 1'b0;
               phase_in      = PH_SP_A;
            end
            PH_SP_A: begin
               res.scl_level = 1'b0;
               res.sda_level = 1'b0;
               phase_in      = PH_SP_B;
            end
            PH_SP_B: begin
               res.sda_level = 1'b0;
               phase_in      = PH_SP_C;
            end
            PH_SP_C: begin
               // a read turns around with a stop and a new start after the register address
               if (!fault_ff && is_read_ff && stage_ff == STG_REG) begin
                  stage_in = STG_ADDR_R;
                  phase_in = PH_ST_A;
               end else begin
                  res.done_res   = 1'b1;
                  res.nack_error = fault_ff;
                  res.read_byte  = (is_read_ff && !fault_ff) ? captured_byte_ff : '0;
                  if (fault_ff) begin
                     captured_byte_in = '0;
                  end
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               res.busy_res = 1'b0;
               phase_in     = PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      if (pop) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         stage_ff           <= STG_ADDR_W;
         bit_count_ff       <= '0;
         shift_byte_ff      <= '0;
         wait_count_ff      <= '0;
         captured_byte_ff   <= '0;
         is_read_ff         <= 1'b0;
         fault_ff           <= 1'b0;
         latched_address_ff <= '0;
         latched_value_ff   <= '0;
         slave_address_ff   <= i2cra_pkg::SLAVE_ADDRESS_RESET;
         ack_timeout_ff     <= i2cra_pkg::ACK_TIMEOUT_RESET;
         rsp_valid_ff       <= 1'b0;
      end else begin
         phase_ff           <= phase_in;
         stage_ff           <= stage_in;
         bit_count_ff       <= bit_count_in;
         shift_byte_ff      <= shift_byte_in;
         wait_count_ff      <= wait_count_in;
         captured_byte_ff   <= captured_byte_in;
         is_read_ff         <= is_read_in;
         fault_ff           <= fault_in;
         latched_address_ff <= latched_address_in;
         latched_value_ff   <= latched_value_in;
         slave_address_ff   <= slave_address_in;
         ack_timeout_ff     <= ack_timeout_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      rsp_result_ff <= rsp_result_in;
   end

endmodule

FILE: rtl/i2cra_checker.sv
// port checker for the i2c register access master, bound to the top level
`include "assert_macros.svh"

module i2cra_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [i2cra_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic [i2cra_pkg::MODE_W-1:0]      req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [i2cra_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                              csr_we,
   input logic [i2cra_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [i2cra_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   `ASSERT_IMPLY(a_done_is_busy, clock, reset, rsp_tvalid && rsp_tdata[4], rsp_tdata[3], "done outside busy")
   `ASSERT_IMPLY(a_nack_on_done, clock, reset, rsp_tvalid && rsp_tdata[5], rsp_tdata[4], "nack error without done")
   `ASSERT_IMPLY(a_byte_on_done, clock, reset, rsp_tvalid && (rsp_tdata[13:6] != 8'd0), rsp_tdata[4] && !rsp_tdata[5], "read byte outside a good done")
   `ASSERT_IMPLY(a_released_low, clock, reset, rsp_tvalid && !rsp_tdata[2], !rsp_tdata[1], "released data line shows high level")
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

endmodule

bind i2c_register_access_master i2cra_checker u_checker (.*);
